// ===== rtl/aes_pkg.sv =====
// AES-128 package: S-box tables, GF(2^8) helpers, round functions.
// No dependencies; used by every module of the block cipher.
package aes_pkg;

    localparam int BLOCK_W   = 128;
    localparam int HALF_W    = 64;
    localparam int NUM_ROUND = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [BLOCK_W-1:0] block_t;

    // Control that travels with each pipeline stage.
    typedef struct packed {
        logic valid;
        logic op;
    } stage_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [NUM_ROUND] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // Byte i of a block, byte 0 in the top bits.
    function automatic logic [7:0] get_byte(input block_t s, input int i);
        return s[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic block_t sub_shift(input block_t s);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[BLOCK_W-1-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c+r) & 3))];
        return t;
    endfunction

    function automatic block_t inv_sub_shift(input block_t s);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[BLOCK_W-1-8*(r+4*c) -: 8] =
                    INV_SBOX[get_byte(s, r + 4*((c-r+4) & 3))];
        return t;
    endfunction

    function automatic block_t mix(input block_t s);
        block_t t;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);   a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2); a3 = get_byte(s, 4*c+3);
            t[BLOCK_W-1-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            t[BLOCK_W-1-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            t[BLOCK_W-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            t[BLOCK_W-1-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return t;
    endfunction

    // InvMixColumns as MixColumns of a pre-multiplied column.
    function automatic block_t inv_mix(input block_t s);
        block_t u;
        logic [7:0] a0, a1, a2, a3, e, o;
        u = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);   a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2); a3 = get_byte(s, 4*c+3);
            e = xt(xt(a0 ^ a2));
            o = xt(xt(a1 ^ a3));
            u[BLOCK_W-1-8*(4*c)   -: 8] = a0 ^ e;
            u[BLOCK_W-1-8*(4*c+1) -: 8] = a1 ^ o;
            u[BLOCK_W-1-8*(4*c+2) -: 8] = a2 ^ e;
            u[BLOCK_W-1-8*(4*c+3) -: 8] = a3 ^ o;
        end
        return mix(u);
    endfunction

    // One step of the forward key schedule: round key k-1 to k (rnd = k-1).
    function automatic block_t next_key(input block_t k, input int rnd);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {SBOX[w3[23:16]] ^ RCON[rnd], SBOX[w3[15:8]], SBOX[w3[7:0]],
             SBOX[w3[31:24]]};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ===== rtl/aes_key_sched.sv =====
// AES-128 key schedule: one round key per cycle after reset or a key write.
// Depends on aes_pkg.
module aes_key_sched (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 key_wr,
    input  aes_pkg::block_t      key_in,
    output aes_pkg::block_t      enc_key [11],
    output aes_pkg::block_t      dec_key [11],
    output logic                 busy
);
    import aes_pkg::*;

    block_t     key_reg [11];
    block_t     ikey_reg [11];
    logic [3:0] step_reg, step_next;
    logic       busy_reg, busy_next;
    block_t     nk;

    assign nk = next_key(key_reg[step_reg[3:0] - 4'd1], int'(step_reg) - 1);

    always_comb begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (key_wr) begin
            step_next = 4'd1;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (step_reg == 4'(NUM_ROUND)) busy_next = 1'b0;
            else step_next = step_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 4'd1;
            busy_reg <= 1'b1;
            key_reg[0] <= '0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            if (key_wr) key_reg[0] <= key_in;
        end
        if (busy_reg && !key_wr) begin
            key_reg[step_reg] <= nk;
            if (step_reg != 4'(NUM_ROUND)) ikey_reg[step_reg] <= inv_mix(nk);
        end
    end

    always_comb begin
        for (int k = 0; k < 11; k++) begin
            enc_key[k] = key_reg[k];
            dec_key[k] = ikey_reg[k];
        end
        dec_key[0]  = key_reg[0];
        dec_key[10] = key_reg[10];
    end

    assign busy = busy_reg;

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (step_reg >= 4'd1 && step_reg <= 4'(NUM_ROUND)))
        else $error("key schedule step out of range");
    a_wr_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        key_wr |=> (busy_reg && step_reg == 4'd1))
        else $error("key write did not restart schedule");
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !key_wr && step_reg == 4'(NUM_ROUND)) |=> !busy_reg)
        else $error("schedule did not finish");
`endif
endmodule

// ===== rtl/aes128_block_cipher.sv =====
// AES-128 ECB cipher top level: config port, key schedule, 11-stage round pipeline.
// Depends on aes_pkg and aes_key_sched.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser=op, s_tdata={block_low,block_high}
//  m_      | out | m_tvalid/m_tready  | m_tdata={result_low,result_high}
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (key_high, key_low)
//
// One block enters per cycle while the pipe advances and no key update is under
// way; it passes the initial AddRoundKey stage, then one AES round per stage.
// The stall is global: when the output register holds an untaken result,
// every stage holds, so nothing is lost or repeated.
// After reset the key schedule makes one round key per cycle; after a key write
// the write is first latched in a register, then the schedule runs the same way;
// no request is taken meanwhile.
module aes128_block_cipher (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [127:0]                 s_tdata,  // block_high[63:0], block_low[127:64]
    input  logic                         s_tuser,  // op
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [127:0]                 m_tdata,  // result_high[63:0], result_low[127:64]
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [aes_pkg::CFG_IDX_W:0]  cfg_index,
    input  logic [63:0]                  cfg_data
);
    import aes_pkg::*;

    localparam int NSTG = NUM_ROUND;

    logic [63:0] key_hi_reg, key_lo_reg;
    logic        key_wr_reg;
    block_t      enc_key [11];
    block_t      dec_key [11];
    logic        ks_busy;
    logic        adv;

    stage_ctl_t  ctl_reg [NSTG+1];
    block_t      st_reg  [NSTG+1];
    block_t      in_blk;

    assign cfg_ready = 1'b1;

    // Take key writes; index beyond the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
            key_wr_reg <= 1'b0;
        end else begin
            key_wr_reg <= 1'b0;
            if (cfg_valid && cfg_index[CFG_IDX_W] == 1'b0) begin
                key_wr_reg <= 1'b1;
                if (cfg_index[CFG_IDX_W-1:0] == REG_KEY_HIGH) key_hi_reg <= cfg_data;
                else key_lo_reg <= cfg_data;
            end
        end
    end

    aes_key_sched u_ks (
        .aclk    (aclk),
        .aresetn (aresetn),
        .key_wr  (key_wr_reg),
        .key_in  ({key_hi_reg, key_lo_reg}),
        .enc_key (enc_key),
        .dec_key (dec_key),
        .busy    (ks_busy)
    );

    // Advance the whole pipe unless the output holds an untaken result.
    assign adv      = !ctl_reg[NSTG].valid || m_tready;
    assign s_tready = adv && !ks_busy && !key_wr_reg;
    assign in_blk   = {s_tdata[63:0], s_tdata[127:64]};

    // Stage 0: initial AddRoundKey.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg[0].valid <= 1'b0;
        end else if (adv) begin
            ctl_reg[0].valid <= s_tvalid && s_tready;
        end
        if (adv) begin
            ctl_reg[0].op <= s_tuser;
            st_reg[0] <= in_blk ^ ((s_tuser == OP_DECRYPT) ? enc_key[10] : enc_key[0]);
        end
    end

    // Rounds 1..10, one per stage.
    for (genvar g = 1; g <= NSTG; g++) begin : g_round
        block_t rnd_out;
        always_comb begin
            if (ctl_reg[g-1].op == OP_DECRYPT) begin
                rnd_out = inv_sub_shift(st_reg[g-1]);
                if (g != NSTG) rnd_out = inv_mix(rnd_out);
                rnd_out = rnd_out ^ dec_key[NSTG-g];
            end else begin
                rnd_out = sub_shift(st_reg[g-1]);
                if (g != NSTG) rnd_out = mix(rnd_out);
                rnd_out = rnd_out ^ enc_key[g];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[g].valid <= 1'b0;
            end else if (adv) begin
                ctl_reg[g].valid <= ctl_reg[g-1].valid;
            end
            if (adv) begin
                ctl_reg[g].op <= ctl_reg[g-1].op;
                st_reg[g]     <= rnd_out;
            end
        end
    end

    assign m_tvalid = ctl_reg[NSTG].valid;
    assign m_tdata  = {st_reg[NSTG][63:0], st_reg[NSTG][127:64]};

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ks_busy |-> !s_tready)
        else $error("request taken during key expansion");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && ctl_reg[NSTG-1].valid) |=> m_tvalid)
        else $error("pipeline dropped a request");
`endif
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the AES-128 ECB block cipher top level.
// Depends on aes_pkg (codes, widths) and aes128_block_cipher; builds its own S-box.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    localparam logic [CFG_IDX_W:0] IDX_KEY_HIGH = {1'b0, REG_KEY_HIGH};
    localparam logic [CFG_IDX_W:0] IDX_KEY_LOW  = {1'b0, REG_KEY_LOW};
    // indexes past the two key registers; the block must drop these writes
    localparam logic [CFG_IDX_W:0] IDX_SPARE_A  = 2'd2;
    localparam logic [CFG_IDX_W:0] IDX_SPARE_B  = 2'd3;
    localparam logic [63:0]        ONES         = 64'hffff_ffff_ffff_ffff;
    localparam int                 DRAIN_CYCLES = 40;
    localparam int                 LONG_HOLD    = 300;

    // byte i of a block sits at index 15-i, so a plain cast keeps byte order
    typedef logic [15:0][7:0] aes_state_t;

    typedef struct {
        logic        op;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        known;     // expected block typed in below
        block_t      known_res; // {result_high, result_low}
    } vector_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // block_high[63:0], block_low[127:64]
    logic         s_tuser;   // op
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // result_high[63:0], result_low[127:64]
    logic         cfg_valid;
    logic         cfg_ready;
    logic [CFG_IDX_W:0] cfg_index;
    logic [63:0]  cfg_data;

    // predictor state: own copy of the key registers and the schedule
    logic [7:0]   fwd_box [256];
    logic [7:0]   rev_box [256];
    logic [63:0]  key_hi_q, key_lo_q;
    block_t       enc_keys [11];
    block_t       dec_keys [10];

    block_t       pending_results [$];  // in m_tdata layout
    int           fail_count;
    bit           calm;          // no idling on either side
    bit           long_hold_req; // ask the receiver for one long hold-off

    vector_t      directed [12];

    aes128_block_cipher i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // GF(2^8) arithmetic and the round transforms
    // ---------------------------------------------------------------
    function automatic logic [7:0] gf_dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = gf_dbl(a);
        end
        return acc;
    endfunction

    // S-box from the field inverse and the affine map
    function automatic void build_boxes();
        logic [7:0] inv, s;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_box[x] = s;
            rev_box[s] = x[7:0];
        end
    endfunction

    function automatic aes_state_t subst_shift(input aes_state_t s, input bit reverse);
        aes_state_t t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                if (reverse)
                    t[15-(r+4*c)] = rev_box[s[15-(r+4*((c-r+4)&3))]];
                else
                    t[15-(r+4*c)] = fwd_box[s[15-(r+4*((c+r)&3))]];
        return t;
    endfunction

    function automatic aes_state_t mix_columns(input aes_state_t s, input bit reverse);
        aes_state_t t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[15-4*c]; a1 = s[14-4*c]; a2 = s[13-4*c]; a3 = s[12-4*c];
            if (reverse) begin
                t[15-4*c] = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^
                            gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
                t[14-4*c] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^
                            gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
                t[13-4*c] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^
                            gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
                t[12-4*c] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^
                            gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
            end else begin
                t[15-4*c] = gf_mul(a0, 8'd2) ^ gf_mul(a1, 8'd3) ^ a2 ^ a3;
                t[14-4*c] = a0 ^ gf_mul(a1, 8'd2) ^ gf_mul(a2, 8'd3) ^ a3;
                t[13-4*c] = a0 ^ a1 ^ gf_mul(a2, 8'd2) ^ gf_mul(a3, 8'd3);
                t[12-4*c] = gf_mul(a0, 8'd3) ^ a1 ^ a2 ^ gf_mul(a3, 8'd2);
            end
        end
        return t;
    endfunction

    // Expand the held key into the forward and equivalent-inverse schedules.
    function automatic void expand_schedule();
        logic [31:0] w [4];
        logic [31:0] t;
        logic [7:0]  rc;
        enc_keys[0] = {key_hi_q, key_lo_q};
        rc = 8'h01;
        for (int k = 1; k <= NUM_ROUND; k++) begin
            for (int j = 0; j < 4; j++) w[j] = enc_keys[k-1][127-32*j -: 32];
            t = {fwd_box[w[3][23:16]] ^ rc, fwd_box[w[3][15:8]],
                 fwd_box[w[3][7:0]], fwd_box[w[3][31:24]]};
            w[0] ^= t; w[1] ^= w[0]; w[2] ^= w[1]; w[3] ^= w[2];
            enc_keys[k] = {w[0], w[1], w[2], w[3]};
            rc = gf_dbl(rc);
        end
        for (int r = 1; r < NUM_ROUND; r++)
            dec_keys[r] = mix_columns(aes_state_t'(enc_keys[NUM_ROUND-r]), 1'b1);
    endfunction

    // Cipher or equivalent inverse cipher of one block, {high, low}.
    function automatic block_t cipher_block(input logic op, input block_t blk);
        aes_state_t s;
        if (op == OP_ENCRYPT) begin
            s = aes_state_t'(blk ^ enc_keys[0]);
            for (int r = 1; r < NUM_ROUND; r++)
                s = mix_columns(subst_shift(s, 1'b0), 1'b0) ^ enc_keys[r];
            s = subst_shift(s, 1'b0) ^ enc_keys[NUM_ROUND];
        end else begin
            s = aes_state_t'(blk ^ enc_keys[NUM_ROUND]);
            for (int r = 1; r < NUM_ROUND; r++)
                s = mix_columns(subst_shift(s, 1'b1), 1'b1) ^ dec_keys[r];
            s = subst_shift(s, 1'b1) ^ enc_keys[0];
        end
        return block_t'(s);
    endfunction

    // ---------------------------------------------------------------
    // Mismatch reporting and result checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        block_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[63:0] !== want[63:0])
                    report_mismatch($sformatf("result_high %h, want %h",
                                              m_tdata[63:0], want[63:0]));
                if (m_tdata[127:64] !== want[127:64])
                    report_mismatch($sformatf("result_low %h, want %h",
                                              m_tdata[127:64], want[127:64]));
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        int hold_cycles;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                // count the hold-off here while the sender keeps pushing
                for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
                    @(negedge aclk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    // Offer one request; enter and leave at a falling edge.
    task automatic send_block(input logic op, input logic [63:0] hi,
                              input logic [63:0] lo, input bit typed,
                              input block_t typed_res);
        block_t res;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {lo, hi};
        // hold the request until the block takes it
        do @(posedge aclk); while (!s_tready);
        res = typed ? typed_res : cipher_block(op, {hi, lo});
        pending_results.push_back({res[63:0], res[127:64]});
        @(negedge aclk);
    endtask

    // Write one register once the pipeline has drained; track the key here.
    task automatic write_reg(input logic [CFG_IDX_W:0] idx, input logic [63:0] val);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == IDX_KEY_HIGH) key_hi_q = val;
        else if (idx == IDX_KEY_LOW) key_lo_q = val;
        expand_schedule();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand_half();
        case ($urandom_range(0, 9))
            0:       return 64'h0;
            1:       return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        logic [63:0] phase_hi [5];
        logic [63:0] phase_lo [5];
        int          wait_cycles;
        build_boxes();
        fail_count    = 0;
        calm          = 1'b0;
        long_hold_req = 1'b0;
        key_hi_q      = 64'h0;
        key_lo_q      = 64'h0;
        expand_schedule();

        // zero key right after reset: zero block, its inverse, extremes
        directed[0]  = '{OP_ENCRYPT, 64'h0, 64'h0, 1'b1,
                         128'h66e94bd4ef8a2c3b_884cfa59ca342b2e};
        directed[1]  = '{OP_DECRYPT, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1,
                         128'h0};
        directed[2]  = '{OP_ENCRYPT, ONES, ONES, 1'b0, '0};
        directed[3]  = '{OP_DECRYPT, ONES, ONES, 1'b0, '0};
        directed[4]  = '{OP_ENCRYPT, ONES, 64'h0, 1'b0, '0};
        directed[5]  = '{OP_DECRYPT, 64'h0, ONES, 1'b0, '0};
        // standard test key; out-of-range writes in between must not touch it
        directed[6]  = '{OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                         128'h69c4e0d86a7b0430_d8cdb78070b4c55a};
        directed[7]  = '{OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
                         128'h00112233445566778899aabbccddeeff};
        directed[8]  = '{OP_ENCRYPT, 64'h8000000000000000, 64'h1, 1'b0, '0};
        directed[9]  = '{OP_DECRYPT, 64'h1, 64'h8000000000000000, 1'b0, '0};
        directed[10] = '{OP_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, '0};
        directed[11] = '{OP_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, '0};

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = OP_ENCRYPT;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = IDX_KEY_HIGH;
        cfg_data  = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < 12; i++) begin
            if (i == 6) begin
                write_reg(IDX_KEY_HIGH, 64'h0001020304050607);
                write_reg(IDX_KEY_LOW,  64'h08090a0b0c0d0e0f);
                write_reg(IDX_SPARE_A,  {$urandom, $urandom});
                write_reg(IDX_SPARE_B,  ONES);
            end
            send_block(directed[i].op, directed[i].hi, directed[i].lo,
                       directed[i].known, directed[i].known_res);
        end

        // random phases, one key setting each, extremes among them
        phase_hi = '{ONES, {$urandom, $urandom}, {$urandom, $urandom}, 64'h0, 64'h0};
        phase_lo = '{ONES, {$urandom, $urandom}, 64'h0, {$urandom, $urandom}, 64'h0};
        for (int p = 0; p < 5; p++) begin
            write_reg(IDX_KEY_HIGH, phase_hi[p]);
            write_reg(IDX_KEY_LOW,  phase_lo[p]);
            if (p == 1) long_hold_req = 1'b1;
            if (p == 4) calm = 1'b1;
            for (int n = 0; n < 228; n++)
                send_block(1'($urandom_range(0, 1)), rand_half(), rand_half(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000) begin
            @(negedge aclk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never came", pending_results.size()));
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/aes_pkg.sv
rtl/aes_key_sched.sv
rtl/aes128_block_cipher.sv
tb/sv/tb.sv
